// File: rtl/mbd_pkg.sv
`timescale 1ns / 1ps

package mbd_pkg;

   localparam int MAX_CHANNELS   = 256;
   localparam int MAX_ACCUMULATE = 1024;

   localparam int CHAN_W      = $clog2(MAX_CHANNELS);
   localparam int NCH_W       = $clog2(MAX_CHANNELS + 1);
   localparam int ACC_W       = $clog2(MAX_ACCUMULATE + 1);
   localparam int ROUND_W     = $clog2(MAX_ACCUMULATE);
   localparam int SAMPLE_W    = 32;
   localparam int SUM_W       = 43;
   localparam int DIV_COUNT_W = $clog2(SUM_W + 1);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_ACCUMULATE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_CHANNELS     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_MODE      = 2'd2;

   localparam logic MODE_SIGNED16   = 1'b0;
   localparam logic MODE_UNSIGNED32 = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADD,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// File: rtl/mbd_sum_ram.sv
`timescale 1ns / 1ps

module mbd_sum_ram (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [mbd_pkg::CHAN_W-1:0]        wr_addr,
   input  logic [mbd_pkg::SUM_W-1:0]         wr_data,
   input  logic                              rd_en,
   input  logic [mbd_pkg::CHAN_W-1:0]        rd_addr,
   output logic [mbd_pkg::SUM_W-1:0]         rd_data
);

   logic [mbd_pkg::SUM_W-1:0] mem_ff [mbd_pkg::MAX_CHANNELS];
   logic [mbd_pkg::SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/mbd_divider.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Signed mode divides the
// magnitude and negates the 16-bit result, which truncates toward zero.
module mbd_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [mbd_pkg::SUM_W-1:0]         dividend,
   input  logic [mbd_pkg::ACC_W-1:0]         divisor,
   input  logic                              mode,
   output mbd_pkg::div_status_type           status,
   output logic [mbd_pkg::SAMPLE_W-1:0]      quotient
);

   logic [mbd_pkg::SUM_W-1:0]       quo_ff, quo_in;
   logic [mbd_pkg::ACC_W-1:0]       rem_ff, rem_in;
   logic [mbd_pkg::ACC_W-1:0]       div_ff;
   logic [mbd_pkg::DIV_COUNT_W-1:0] count_ff;
   logic                            neg_ff;
   logic                            mode_ff;
   logic                            busy_ff;
   logic                            done_ff;

   logic [mbd_pkg::ACC_W:0]   trial;
   logic [mbd_pkg::ACC_W:0]   diff;
   logic                      ge;
   logic                      neg_start;
   logic [mbd_pkg::SUM_W-1:0] magnitude;
   logic [15:0]               low_half;

   assign neg_start = (mode == mbd_pkg::MODE_SIGNED16) && dividend[mbd_pkg::SUM_W-1];
   assign magnitude = neg_start ? (~dividend + 1'b1) : dividend;

   assign trial  = {rem_ff, quo_ff[mbd_pkg::SUM_W-1]};
   assign diff   = trial - {1'b0, div_ff};
   assign ge     = (trial >= {1'b0, div_ff});
   assign rem_in = ge ? diff[mbd_pkg::ACC_W-1:0] : trial[mbd_pkg::ACC_W-1:0];
   assign quo_in = {quo_ff[mbd_pkg::SUM_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= mbd_pkg::DIV_COUNT_W'(mbd_pkg::SUM_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == mbd_pkg::DIV_COUNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= magnitude;
         rem_ff  <= '0;
         div_ff  <= divisor;
         neg_ff  <= neg_start;
         mode_ff <= mode;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign low_half = neg_ff ? (~quo_ff[15:0] + 1'b1) : quo_ff[15:0];
   assign quotient = (mode_ff == mbd_pkg::MODE_UNSIGNED32) ? quo_ff[mbd_pkg::SAMPLE_W-1:0]
                                                           : {16'b0, low_half};

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// File: rtl/multichannel_boxcar_decimator_unit.sv
`timescale 1ns / 1ps

// Boxcar decimating averager over interleaved channels.
// req_*: one sample per request; channel position is tracked internally and
//   restarts at channel 0 after reset or any register write. Reset also sets
//   the registers to accumulate count 1, one channel, signed 16-bit samples.
// rsp_*: one average per channel on the last round of a block, carrying its
//   channel index and a last-of-frame flag. Earlier rounds give no response.
// csr_*: write-only registers (accumulate count, channel count, sample mode).
//   A write to a listed register clears all sums and counters.
// Flow: a sample that only accumulates is accepted, then summed by a sum
//   RAM read-modify-write. A sample that completes a sum also starts the
//   bit-serial divider (one bit per cycle over 43 bits); the quotient then
//   moves into the output register, and the next request is taken in the
//   cycle after. With an accumulate count of 1 samples skip RAM and divider.
// Sums live in a 256-entry RAM; a flop valid bit per entry makes the RAM read
//   as zero after reset or a register write, so no clearing pass is needed.
// Requests are stalled from acceptance until the sample is summed or its
//   result has moved into the output register. A stalled receiver holds the
//   response there and keeps the next result, and the request side, waiting.
module multichannel_boxcar_decimator_unit (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mbd_pkg::SAMPLE_W-1:0]         req_sample_bits,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mbd_pkg::SAMPLE_W-1:0]         rsp_average_bits,
   output logic [mbd_pkg::CHAN_W-1:0]           rsp_channel,
   output logic                                 rsp_last_of_frame,

   input  logic                                 csr_write_enable,
   input  logic [mbd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mbd_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   mbd_pkg::state_type state_ff, state_in;

   logic [mbd_pkg::ACC_W-1:0]    acc_ff;
   logic [mbd_pkg::NCH_W-1:0]    nch_ff;
   logic                         mode_ff;

   logic [mbd_pkg::CHAN_W-1:0]   pos_ff, pos_in;
   logic [mbd_pkg::ROUND_W-1:0]  round_ff, round_in;
   logic [mbd_pkg::MAX_CHANNELS-1:0] valid_ff;

   logic [mbd_pkg::CHAN_W-1:0]   chan_ff;
   logic                         last_ff;
   logic                         emit_ff;
   logic [mbd_pkg::SUM_W-1:0]    sample_ff;
   logic [mbd_pkg::SAMPLE_W-1:0] result_ff;

   logic                         rsp_valid_ff;
   logic [mbd_pkg::SAMPLE_W-1:0] rsp_average_ff;
   logic [mbd_pkg::CHAN_W-1:0]   rsp_channel_ff;
   logic                         rsp_last_ff;

   logic [mbd_pkg::ACC_W-1:0]    nacc_eff;
   logic [mbd_pkg::NCH_W-1:0]    nch_eff;
   logic [mbd_pkg::CHAN_W-1:0]   pos_cur;
   logic                         last_ch;
   logic                         pass;
   logic                         round_done;
   logic                         accept;
   logic                         csr_restart;
   logic                         out_free;
   logic                         out_load;
   logic [mbd_pkg::SUM_W-1:0]    sample_ext;
   logic [mbd_pkg::SAMPLE_W-1:0] pass_value;

   logic                         ram_wr_en;
   logic [mbd_pkg::SUM_W-1:0]    ram_wr_data;
   logic [mbd_pkg::SUM_W-1:0]    ram_rd_data;
   logic [mbd_pkg::SUM_W-1:0]    sum_old;
   logic [mbd_pkg::SUM_W-1:0]    sum_new;

   logic                         div_start;
   mbd_pkg::div_status_type      div_status;
   logic [mbd_pkg::SAMPLE_W-1:0] div_quotient;

   // effective register values: zero acts as one, large values saturate
   always_comb begin
      if (acc_ff == '0) begin
         nacc_eff = mbd_pkg::ACC_W'(1);
      end else if (acc_ff > mbd_pkg::ACC_W'(mbd_pkg::MAX_ACCUMULATE)) begin
         nacc_eff = mbd_pkg::ACC_W'(mbd_pkg::MAX_ACCUMULATE);
      end else begin
         nacc_eff = acc_ff;
      end
      if (nch_ff == '0) begin
         nch_eff = mbd_pkg::NCH_W'(1);
      end else if (nch_ff > mbd_pkg::NCH_W'(mbd_pkg::MAX_CHANNELS)) begin
         nch_eff = mbd_pkg::NCH_W'(mbd_pkg::MAX_CHANNELS);
      end else begin
         nch_eff = nch_ff;
      end
   end

   assign pos_cur    = ({1'b0, pos_ff} >= nch_eff) ? '0 : pos_ff;
   assign last_ch    = ({1'b0, pos_cur} == (nch_eff - 1'b1));
   assign pass       = (nacc_eff == mbd_pkg::ACC_W'(1));
   assign round_done = ({1'b0, round_ff} >= (nacc_eff - 1'b1));
   assign accept     = req_valid && !req_stall;
   assign csr_restart = csr_write_enable &&
                        ((csr_index == mbd_pkg::CSR_ACCUMULATE_COUNT) ||
                         (csr_index == mbd_pkg::CSR_NUM_CHANNELS) ||
                         (csr_index == mbd_pkg::CSR_SAMPLE_MODE));

   assign sample_ext = (mode_ff == mbd_pkg::MODE_UNSIGNED32)
                       ? {{(mbd_pkg::SUM_W - mbd_pkg::SAMPLE_W){1'b0}}, req_sample_bits}
                       : {{(mbd_pkg::SUM_W - 16){req_sample_bits[15]}}, req_sample_bits[15:0]};
   assign pass_value = (mode_ff == mbd_pkg::MODE_UNSIGNED32) ? req_sample_bits
                                                             : {16'b0, req_sample_bits[15:0]};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // read-modify-write; entries never written since restart read as zero
   assign sum_old     = valid_ff[chan_ff] ? ram_rd_data : '0;
   assign sum_new     = sum_old + sample_ff;
   assign ram_wr_data = emit_ff ? '0 : sum_new;

   // next position and round, applied when a request is accepted
   always_comb begin
      pos_in   = last_ch ? '0 : pos_cur + 1'b1;
      round_in = round_ff;
      if (pass) begin
         round_in = '0;
      end else if (last_ch) begin
         round_in = round_done ? '0 : round_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbd_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = pass ? mbd_pkg::ST_DELIVER : mbd_pkg::ST_ADD;
            end
         end
         mbd_pkg::ST_ADD: begin
            state_in = emit_ff ? mbd_pkg::ST_DIVIDE : mbd_pkg::ST_IDLE;
         end
         mbd_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = mbd_pkg::ST_DELIVER;
            end
         end
         mbd_pkg::ST_DELIVER: begin
            if (out_free) begin
               state_in = mbd_pkg::ST_IDLE;
            end
         end
         default: state_in = mbd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      ram_wr_en = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         mbd_pkg::ST_IDLE:    req_stall = 1'b0;
         mbd_pkg::ST_ADD: begin
            ram_wr_en = 1'b1;
            div_start = emit_ff;
         end
         mbd_pkg::ST_DIVIDE:  ;
         mbd_pkg::ST_DELIVER: out_load = out_free;
         default:             ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mbd_pkg::ST_IDLE;
         acc_ff   <= mbd_pkg::ACC_W'(1);
         nch_ff   <= mbd_pkg::NCH_W'(1);
         mode_ff  <= mbd_pkg::MODE_SIGNED16;
         pos_ff   <= '0;
         round_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               mbd_pkg::CSR_ACCUMULATE_COUNT: acc_ff <= csr_write_data[mbd_pkg::ACC_W-1:0];
               mbd_pkg::CSR_NUM_CHANNELS:     nch_ff <= csr_write_data[mbd_pkg::NCH_W-1:0];
               mbd_pkg::CSR_SAMPLE_MODE:      mode_ff <= csr_write_data[0];
               default:                       ;
            endcase
         end
         if (csr_restart) begin
            pos_ff   <= '0;
            round_ff <= '0;
            valid_ff <= '0;
         end else begin
            if (accept) begin
               pos_ff   <= pos_in;
               round_ff <= round_in;
            end
            if (ram_wr_en) begin
               valid_ff[chan_ff] <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chan_ff   <= pos_cur;
         last_ff   <= last_ch;
         emit_ff   <= round_done;
         sample_ff <= sample_ext;
      end
      if (accept && pass) begin
         result_ff <= pass_value;
      end else if (div_status.done) begin
         result_ff <= div_quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_average_ff <= result_ff;
         rsp_channel_ff <= chan_ff;
         rsp_last_ff    <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average_bits  = rsp_average_ff;
   assign rsp_channel       = rsp_channel_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   mbd_sum_ram u_sum_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (chan_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (pos_cur),
      .rd_data (ram_rd_data)
   );

   mbd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (nacc_eff),
      .mode     (mode_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == mbd_pkg::ST_DIVIDE))
      else $error("divider finished outside of divide state");

   a_rsp_from_deliver: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == mbd_pkg::ST_DELIVER))
      else $error("response raised without a finished request");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pos_ff} < nch_eff) || $past(csr_write_enable))
      else $error("channel position beyond channel count");

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

endmodule
